// ===== rtl/tsvf_pkg.sv =====
// tsvf_pkg: widths, character codes and register indexes for the visible-text formatter.
// No dependencies; used by the top level.
package tsvf_pkg;

    // Line counter: decimal digits, four bits each
    localparam int C_NUM_DIGITS = 6;
    localparam int C_CNT_W      = 4 * C_NUM_DIGITS;

    // Longest run: number, tab, up to three prefix bytes, the byte itself
    localparam int C_MID_MAX = 3;
    localparam int C_PRE_LEN = C_NUM_DIGITS + 1;
    localparam int C_RUN_MAX = C_PRE_LEN + C_MID_MAX + 1;
    localparam int C_LEN_W   = $clog2(C_RUN_MAX + 1);

    // Configuration port
    localparam int C_CFG_IDX_W  = 3;
    localparam int C_CFG_DATA_W = 2;

    localparam logic [C_CFG_IDX_W-1:0] C_REG_NUMBER_MODE      = 3'd0;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_FOLD_BLANK       = 3'd1;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_SHOW_ENDS        = 3'd2;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_SHOW_TABS        = 3'd3;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_SHOW_NONPRINTING = 3'd4;

    localparam logic [1:0] C_NUM_NONE  = 2'd0;
    localparam logic [1:0] C_NUM_ALL   = 2'd1;

    // Character codes
    localparam logic [7:0] C_CHR_TAB    = 8'h09;
    localparam logic [7:0] C_CHR_NL     = 8'h0A;
    localparam logic [7:0] C_CHR_SPACE  = 8'h20;
    localparam logic [7:0] C_CHR_DOLLAR = 8'h24;
    localparam logic [7:0] C_CHR_DASH   = 8'h2D;
    localparam logic [7:0] C_CHR_ZERO   = 8'h30;
    localparam logic [7:0] C_CHR_QMARK  = 8'h3F;
    localparam logic [7:0] C_CHR_I      = 8'h49;
    localparam logic [7:0] C_CHR_M      = 8'h4D;
    localparam logic [7:0] C_CHR_CARET  = 8'h5E;
    localparam logic [7:0] C_CHR_DEL    = 8'h7F;
    localparam logic [7:0] C_CHR_CTL_HI = 8'h1F;
    localparam logic [7:0] C_CHR_HI_CTL = 8'h9F;
    localparam logic [7:0] C_CHR_MAX    = 8'hFF;
    localparam logic [7:0] C_CARET_OFS  = 8'h40;
    localparam logic [7:0] C_META_OFS   = 8'h80;

    // True when every digit of the counter is a decimal digit
    function automatic logic f_bcd_ok(input logic [C_CNT_W-1:0] cnt);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < C_NUM_DIGITS; i++) begin
            if (cnt[4*i +: 4] > 4'd9) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

// ===== rtl/tsvf_in_if.sv =====
// tsvf_in_if: valid/ready channel that carries one raw text byte.
// Depends on tsvf_pkg only by convention; the payload width is fixed.
interface tsvf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

// ===== rtl/tsvf_out_if.sv =====
// tsvf_out_if: valid/ready channel that carries one formatted byte and its end-of-run flag.
// No dependencies.
interface tsvf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;

    modport source (output valid, output out_byte, output run_last, input ready);
    modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

// ===== rtl/text_stream_visible_formatter.sv =====
// text_stream_visible_formatter: cat-style visible formatting of a byte stream.
// Depends on tsvf_pkg, tsvf_in_if and tsvf_out_if.
//
//   channel   direction  payload              transaction
//   i_in      in         in_byte[7:0]         valid && ready
//   o_out     out        out_byte, run_last   valid && ready
//   cfg       in         idx[2:0], data[1:0]  i_cfg_we
//
// A byte is expanded in the cycle it is taken and its whole run is loaded into
// an eleven-byte shift buffer; the buffer sends one byte per cycle while the
// output is ready. A run holds the input until its last byte goes out. A
// squeezed newline sends nothing. The next byte is taken in the cycle the
// last byte of the current run goes out. Reset is synchronous; a stalled
// output holds its byte.
module text_stream_visible_formatter
    import tsvf_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [C_CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [C_CFG_DATA_W-1:0] i_cfg_data,
    tsvf_in_if.sink                 i_in,
    tsvf_out_if.source              o_out
);

    // Configuration registers
    logic [1:0] r_number_mode;
    logic       r_fold_blank;
    logic       r_show_ends;
    logic       r_show_tabs;
    logic       r_show_np;

    // Line state
    logic               r_line_start;
    logic               r_after_blank;
    logic [C_CNT_W-1:0] r_cnt;

    // Run buffer
    logic [7:0]         r_buf [C_RUN_MAX];
    logic [7:0]         n_buf [C_RUN_MAX];
    logic [C_LEN_W-1:0] r_len;
    logic [C_LEN_W-1:0] n_len;

    logic               in_xfer;
    logic               out_xfer;
    logic [7:0]         c_in;
    logic               is_nl;
    logic               drop;
    logic               number_it;
    logic               all_nine;
    logic               carry;
    logic [C_CNT_W-1:0] cnt_inc;
    logic               zero_lead;
    logic [3:0]         dgt;
    logic [7:0]         pre [C_PRE_LEN];
    logic [7:0]         mid [C_MID_MAX];
    logic [1:0]         mid_len;
    logic [7:0]         fin;
    logic [7:0]         plain [C_MID_MAX+1];
    logic [7:0]         run [C_RUN_MAX];
    logic [C_LEN_W-1:0] run_len;

    assign c_in     = i_in.in_byte;
    assign is_nl    = (c_in == C_CHR_NL);
    assign out_xfer = o_out.valid && o_out.ready;
    assign in_xfer  = i_in.valid && i_in.ready;

    // Take a byte when the buffer is empty or its last byte leaves now
    assign i_in.ready = (r_len == '0) || ((r_len == C_LEN_W'(1)) && o_out.ready);

    assign o_out.valid    = (r_len != '0);
    assign o_out.out_byte = r_buf[0];
    assign o_out.run_last = (r_len == C_LEN_W'(1));

    // Drop a repeated empty line
    assign drop = r_fold_blank && is_nl && r_after_blank;

    // Mode three numbers nonblank lines like mode two
    always_comb begin
        priority if (r_number_mode == C_NUM_ALL) begin
            number_it = r_line_start;
        end else if (r_number_mode[1]) begin
            number_it = r_line_start && !is_nl;
        end else begin
            number_it = 1'b0;
        end
    end

    // Saturating decimal increment of the line counter
    always_comb begin
        all_nine = 1'b1;
        carry    = 1'b1;
        cnt_inc  = r_cnt;
        for (int i = 0; i < C_NUM_DIGITS; i++) begin
            if (r_cnt[4*i +: 4] != 4'd9) begin
                all_nine = 1'b0;
            end
        end
        if (!all_nine) begin
            for (int i = 0; i < C_NUM_DIGITS; i++) begin
                if (carry) begin
                    if (r_cnt[4*i +: 4] >= 4'd9) begin
                        cnt_inc[4*i +: 4] = 4'd0;
                    end else begin
                        cnt_inc[4*i +: 4] = r_cnt[4*i +: 4] + 4'd1;
                        carry             = 1'b0;
                    end
                end
            end
        end
    end

    // Number field: leading zeros as spaces, last digit always shown, then a tab
    always_comb begin
        zero_lead = 1'b1;
        dgt       = '0;
        for (int i = 0; i < C_NUM_DIGITS; i++) begin
            dgt       = cnt_inc[4*(C_NUM_DIGITS-1-i) +: 4];
            zero_lead = zero_lead && (dgt == 4'd0);
            if (zero_lead && (i != C_NUM_DIGITS - 1)) begin
                pre[i] = C_CHR_SPACE;
            end else begin
                pre[i] = C_CHR_ZERO + {4'd0, dgt};
            end
        end
        pre[C_NUM_DIGITS] = C_CHR_TAB;
    end

    // Prefix bytes and the final byte
    always_comb begin
        mid[0]  = C_CHR_CARET;
        mid[1]  = C_CHR_CARET;
        mid[2]  = C_CHR_CARET;
        mid_len = 2'd0;
        fin     = c_in;
        priority if (is_nl) begin
            if (r_show_ends) begin
                mid[0]  = C_CHR_DOLLAR;
                mid_len = 2'd1;
            end
        end else if (c_in == C_CHR_TAB) begin
            if (r_show_tabs) begin
                mid_len = 2'd1;
                fin     = C_CHR_I;
            end
        end else if (r_show_np) begin
            priority if (c_in <= C_CHR_CTL_HI) begin
                mid_len = 2'd1;
                fin     = c_in + C_CARET_OFS;
            end else if (c_in == C_CHR_DEL) begin
                mid_len = 2'd1;
                fin     = C_CHR_QMARK;
            end else if (c_in == C_CHR_MAX) begin
                mid[0]  = C_CHR_M;
                mid[1]  = C_CHR_DASH;
                mid_len = 2'd3;
                fin     = C_CHR_QMARK;
            end else if (c_in >= C_META_OFS && c_in <= C_CHR_HI_CTL) begin
                mid[0]  = C_CHR_M;
                mid[1]  = C_CHR_DASH;
                mid_len = 2'd3;
                fin     = c_in - C_CARET_OFS;
            end else if (c_in > C_CHR_HI_CTL) begin
                mid[0]  = C_CHR_M;
                mid[1]  = C_CHR_DASH;
                mid_len = 2'd2;
                fin     = c_in - C_META_OFS;
            end else begin
                fin = c_in;
            end
        end else begin
            fin = c_in;
        end
    end

    // Assemble the run: optional number field, then prefix bytes and final byte
    always_comb begin
        for (int k = 0; k <= C_MID_MAX; k++) begin
            plain[k] = (k < int'(mid_len)) ? mid[k] : fin;
        end
        for (int j = 0; j < C_RUN_MAX; j++) begin
            run[j] = C_CHR_SPACE;
        end
        if (number_it) begin
            for (int j = 0; j < C_PRE_LEN; j++) begin
                run[j] = pre[j];
            end
            for (int k = 0; k <= C_MID_MAX; k++) begin
                run[k + C_PRE_LEN] = plain[k];
            end
            run_len = C_LEN_W'(C_PRE_LEN) + C_LEN_W'(mid_len) + C_LEN_W'(1);
        end else begin
            for (int k = 0; k <= C_MID_MAX; k++) begin
                run[k] = plain[k];
            end
            run_len = C_LEN_W'(mid_len) + C_LEN_W'(1);
        end
    end

    // Load a new run on a transaction, else advance on an output transaction
    always_comb begin
        n_buf = r_buf;
        n_len = r_len;
        if (in_xfer) begin
            n_buf = run;
            n_len = drop ? '0 : run_len;
        end else if (out_xfer) begin
            for (int j = 0; j < C_RUN_MAX - 1; j++) begin
                n_buf[j] = r_buf[j+1];
            end
            n_len = r_len - C_LEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len         <= '0;
            r_line_start  <= 1'b1;
            r_after_blank <= 1'b0;
            r_cnt         <= '0;
            r_number_mode <= C_NUM_NONE;
            r_fold_blank  <= 1'b0;
            r_show_ends   <= 1'b0;
            r_show_tabs   <= 1'b0;
            r_show_np     <= 1'b0;
        end else begin
            r_len <= n_len;
            if (in_xfer && !drop) begin
                r_line_start  <= is_nl;
                r_after_blank <= is_nl && r_line_start;
                if (number_it) begin
                    r_cnt <= cnt_inc;
                end
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    C_REG_NUMBER_MODE:      r_number_mode <= i_cfg_data;
                    C_REG_FOLD_BLANK:       r_fold_blank  <= i_cfg_data[0];
                    C_REG_SHOW_ENDS:        r_show_ends   <= i_cfg_data[0];
                    C_REG_SHOW_TABS:        r_show_tabs   <= i_cfg_data[0];
                    C_REG_SHOW_NONPRINTING: r_show_np     <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // A byte is taken only when no earlier byte of a run is left behind
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |-> (!o_out.valid || (o_out.run_last && o_out.ready)))
        else $error("input taken while a run is still pending");

    // A byte that is not the last of its run is followed by more
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && !o_out.run_last) |=> o_out.valid)
        else $error("run ended without its last byte");

    // Counter holds decimal digits only
    a_bcd_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_bcd_ok(r_cnt))
        else $error("line counter holds a digit above nine");

    // Buffer fill never exceeds the longest run
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= C_LEN_W'(C_RUN_MAX))
        else $error("run buffer overfilled");

endmodule
